### design/fst_pkg.sv
// ----------------------------------------------------------------------------
// fst_pkg: shared types and constants of the flow sequence tracker
// Table entry layout, sequencer states and the result of one entry check.
// ----------------------------------------------------------------------------
package fst_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned TMO_W  = 16;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd120;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] last_time;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] now;
  } request_t;

  // Outcome of checking one table entry against the request
  typedef struct packed {
    logic   hit;
    logic   ooo;
    logic   wr_en;
    entry_t wr_entry;
  } eval_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

### design/fst_ram.sv
// ----------------------------------------------------------------------------
// fst_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/fst_eval.sv
// ----------------------------------------------------------------------------
// fst_eval: entry check unit
// Match, expiry and sequence compare for one table entry per cycle.
// ----------------------------------------------------------------------------
module fst_eval (
  input  fst_pkg::entry_t                entry,
  input  fst_pkg::request_t              req,
  input  logic [fst_pkg::TMO_W-1:0]      timeout,
  input  logic                           matched,
  output fst_pkg::eval_res_t             res
);

  logic [fst_pkg::TIME_W-1:0] age;
  logic                       expired;
  logic                       hit;

  assign age     = req.now - entry.last_time;
  assign expired = (req.now >= entry.last_time) &&
                   (age >= fst_pkg::TIME_W'(timeout));
  assign hit     = !matched && (entry.addr == req.addr) && (entry.port == req.port);

  always_comb begin
    res          = '0;
    res.hit      = hit;
    res.wr_entry = entry;
    if (hit) begin
      if (!expired && (entry.seq > req.seq)) begin
        res.ooo = 1'b1;
      end else begin
        res.wr_en              = 1'b1;
        res.wr_entry.seq       = req.seq;
        res.wr_entry.last_time = req.now;
      end
    end else if (expired) begin
      // clear the stale sequence and restart its age
      res.wr_en              = 1'b1;
      res.wr_entry.seq       = '0;
      res.wr_entry.last_time = req.now;
    end
  end

endmodule

### design/flow_sequence_tracker_top.sv
// ----------------------------------------------------------------------------
// flow_sequence_tracker_top: per-client sequence tracker
// Walks the table once per request, one entry per cycle via a single check
// unit, then appends an unknown client if there is room; reports one item.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+--------------------------------
//  s_*       | in        | s_tvalid/s_tready  | s_tdata: client request (96 b)
//  m_*       | out       | m_tvalid/m_tready  | m_tdata: result (40 b)
//  cfg_*     | in        | cfg_wr_en          | cfg_wr_data: timeout_seconds
//
//  Each item walks the filled entries (at most TABLE_DEPTH) before its result
//  is loaded: the walk issues one RAM read a cycle, the check of each entry
//  follows in the next cycle on the registered data, ST_SCAN ends once no
//  read or check is left, and ST_FINISH then loads the result.
//  rst clears the fill count, the sequencer and the output valid; the
//  table RAM is not cleared, entries at or above the fill count are never read.
//  A result that waits at m_* holds the sequencer in its last step only; the
//  next request is accepted while the previous result still waits.
//
module flow_sequence_tracker_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,

  // src_ip[31:0], client_port[47:32], seq_number[63:48], now_seconds[95:64]
  input  logic [95:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,

  // out_of_order[0], stored_seq[16:1], reported_seq[32:17], new_client[33],
  // table_full[34], zero fill [39:35]
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,

  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // Configuration
  logic [fst_pkg::TMO_W-1:0] timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= fst_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout <= cfg_wr_data;
    end
  end

  // Sequencer state
  fst_pkg::state_t state, state_next;

  fst_pkg::request_t req;
  logic [CNT_W-1:0]  slot_count;
  logic [CNT_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  ev_idx;
  logic              pend;
  logic              matched;
  logic [fst_pkg::SEQ_W-1:0] held;
  logic              ooo;

  // Output register
  logic              out_ooo;
  logic [fst_pkg::SEQ_W-1:0] out_stored;
  logic [fst_pkg::SEQ_W-1:0] out_reported;
  logic              out_new;
  logic              out_full;

  // Table RAM ports
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  fst_pkg::entry_t            ram_wdata;
  logic                       ram_re;
  logic [IDX_W-1:0]           ram_raddr;
  logic [fst_pkg::ENTRY_W-1:0] ram_rdata;
  fst_pkg::entry_t            rd_entry;

  fst_pkg::eval_res_t ev;

  logic in_take;
  logic issue;
  logic walk_done;
  logic out_free;
  logic can_append;
  logic finish;

  assign in_take    = s_tvalid && s_tready;
  assign issue      = (state == fst_pkg::ST_SCAN) && (rd_idx < slot_count);
  assign walk_done  = !issue && !pend;
  assign out_free   = !m_tvalid || m_tready;
  assign can_append = !matched && (slot_count < DEPTH_CNT);
  assign finish     = (state == fst_pkg::ST_FINISH) && out_free;
  assign rd_entry   = fst_pkg::entry_t'(ram_rdata);

  fst_ram #(
    .WIDTH (fst_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  fst_eval u_eval (
    .entry   (rd_entry),
    .req     (req),
    .timeout (timeout),
    .matched (matched),
    .res     (ev)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      fst_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = fst_pkg::ST_SCAN;
        end
      end
      fst_pkg::ST_SCAN: begin
        if (walk_done) begin
          state_next = fst_pkg::ST_FINISH;
        end
      end
      fst_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = fst_pkg::ST_IDLE;
        end
      end
      default: state_next = fst_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: RAM port drive and input ready
  always_comb begin
    s_tready  = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rd_idx[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = ev_idx;
    ram_wdata = ev.wr_entry;
    unique case (state)
      fst_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      fst_pkg::ST_SCAN: begin
        ram_re = issue;
        // write-back of entry ev_idx never collides with the read of rd_idx
        ram_we = pend && ev.wr_en;
      end
      fst_pkg::ST_FINISH: begin
        ram_we              = out_free && can_append;
        ram_waddr           = slot_count[IDX_W-1:0];
        ram_wdata.addr      = req.addr;
        ram_wdata.port      = req.port;
        ram_wdata.seq       = req.seq;
        ram_wdata.last_time = req.now;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fst_pkg::ST_IDLE;
      slot_count <= '0;
      rd_idx     <= '0;
      pend       <= 1'b0;
      matched    <= 1'b0;
      ooo        <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        rd_idx  <= '0;
        pend    <= 1'b0;
        matched <= 1'b0;
        ooo     <= 1'b0;
      end
      if (state == fst_pkg::ST_SCAN) begin
        pend <= issue;
        if (issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (pend && ev.hit) begin
          matched <= 1'b1;
          ooo     <= ev.ooo;
        end
      end
      if (finish && can_append) begin
        slot_count <= slot_count + CNT_W'(1);
      end
      // hold the result until taken, load the next one when free
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      req  <= fst_pkg::request_t'({s_tdata[31:0], s_tdata[47:32],
                                   s_tdata[63:48], s_tdata[95:64]});
      held <= '0;
    end
    if ((state == fst_pkg::ST_SCAN) && issue) begin
      ev_idx <= rd_idx[IDX_W-1:0];
    end
    if ((state == fst_pkg::ST_SCAN) && pend && ev.hit) begin
      held <= rd_entry.seq;
    end
    if (finish) begin
      out_ooo      <= ooo;
      out_stored   <= held;
      out_reported <= ooo ? req.seq : '0;
      out_new      <= can_append;
      out_full     <= !matched && !can_append;
    end
  end

  assign m_tdata = {5'b0, out_full, out_new, out_reported, out_stored, out_ooo};

endmodule

### design/fst_checker.sv
// ----------------------------------------------------------------------------
// fst_checker: port-level checks of the flow sequence tracker
// Watches the top level's ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module fst_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready
);

  // one request in flight: ready drops after an accepted item
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in work");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // appended and table-full are exclusive
  a_new_vs_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[33] && m_tdata[34]))
    else $error("new client and table full both set");

  // an out-of-order report comes only from a known client
  a_ooo_known: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (!m_tdata[33] && !m_tdata[34]))
    else $error("out of order on an unknown client");

  // the echoed sequence is zero unless reported
  a_reported_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:17] == 16'd0))
    else $error("reported sequence without out-of-order flag");

endmodule

bind flow_sequence_tracker_top fst_checker u_fst_checker (.*);

### tb/sv/flow_sequence_tracker_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flow_sequence_tracker_top_tb: self-checking bench for the sequence tracker
// Streams client requests through the tracker and keeps a private copy of
// the client table to predict each result. Results are compared in order,
// field by field, across several timeout settings and idle patterns.
// ----------------------------------------------------------------------------
module flow_sequence_tracker_top_tb;

  localparam int unsigned DEPTH           = 16;
  localparam int unsigned POOL_SIZE       = 20;
  localparam int unsigned ITEMS_PER_PHASE = 222;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned MAX_REPORTS     = 10;

  // Request item as it sits on s_tdata: src_ip in the lowest bits
  typedef struct packed {
    logic [fst_pkg::TIME_W-1:0] now;
    logic [fst_pkg::SEQ_W-1:0]  seq;
    logic [fst_pkg::PORT_W-1:0] port;
    logic [fst_pkg::ADDR_W-1:0] addr;
  } client_req_t;

  // Result item as it sits on m_tdata: out_of_order in bit 0
  typedef struct packed {
    logic [4:0]                fill;
    logic                      table_full;
    logic                      new_client;
    logic [fst_pkg::SEQ_W-1:0] reported_seq;
    logic [fst_pkg::SEQ_W-1:0] stored_seq;
    logic                      out_of_order;
  } track_result_t;

  // Private client table plus the queue of results still owed by the block
  class sequence_book;
    logic [fst_pkg::TMO_W-1:0]  timeout;
    logic                       used      [DEPTH];
    logic [fst_pkg::ADDR_W-1:0] slot_addr [DEPTH];
    logic [fst_pkg::PORT_W-1:0] slot_port [DEPTH];
    logic [fst_pkg::SEQ_W-1:0]  slot_seq  [DEPTH];
    logic [fst_pkg::TIME_W-1:0] slot_time [DEPTH];
    int unsigned                fill_count;
    track_result_t              pending_results[$];
    int unsigned       mismatches, n_requests, n_results, n_ooo, n_new, n_full;

    function new();
      timeout    = fst_pkg::TIMEOUT_RESET;
      fill_count = 0;
      mismatches = 0;
      n_requests = 0;
      n_results  = 0;
      n_ooo      = 0;
      n_new      = 0;
      n_full     = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH %0d: %s", mismatches, msg);
    endfunction

    function void note_request(client_req_t r);
      track_result_t res;
      logic          hit;
      logic          aged;
      res = '0;
      hit = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        if (used[i]) begin
          aged = (r.now >= slot_time[i]) && ((r.now - slot_time[i]) >= {16'd0, timeout});
          if (!hit && slot_addr[i] == r.addr && slot_port[i] == r.port) begin
            hit = 1'b1;
            res.stored_seq = slot_seq[i];
            if (!aged && slot_seq[i] > r.seq) begin
              res.out_of_order = 1'b1;
              res.reported_seq = r.seq;
            end else begin
              slot_seq[i]  = r.seq;
              slot_time[i] = r.now;
            end
          end else if (aged) begin
            slot_seq[i]  = '0;
            slot_time[i] = r.now;
          end
        end
      end
      if (!hit) begin
        if (fill_count < DEPTH) begin
          used[fill_count]      = 1'b1;
          slot_addr[fill_count] = r.addr;
          slot_port[fill_count] = r.port;
          slot_seq[fill_count]  = r.seq;
          slot_time[fill_count] = r.now;
          fill_count++;
          res.new_client = 1'b1;
        end else begin
          res.table_full = 1'b1;
        end
      end
      n_requests++;
      n_ooo  += 32'(res.out_of_order);
      n_new  += 32'(res.new_client);
      n_full += 32'(res.table_full);
      pending_results.push_back(res);
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want)
        flag($sformatf("result %0d %s: expected %h, got %h", n_results, name, want, got));
    endfunction

    function void check_result(logic [39:0] data);
      track_result_t got;
      track_result_t want;
      got = track_result_t'(data);
      n_results++;
      if (pending_results.size() == 0) begin
        flag($sformatf("result %0d (%h) with no request pending", n_results, data));
        return;
      end
      want = pending_results.pop_front();
      cmp_field("out_of_order", 16'(want.out_of_order), 16'(got.out_of_order));
      cmp_field("stored_seq",   want.stored_seq,        got.stored_seq);
      cmp_field("reported_seq", want.reported_seq,      got.reported_seq);
      cmp_field("new_client",   16'(want.new_client),   16'(got.new_client));
      cmp_field("table_full",   16'(want.table_full),   16'(got.table_full));
      cmp_field("zero fill",    16'(want.fill),         16'(got.fill));
    endfunction

    function void close_out();
      if (pending_results.size() != 0)
        flag($sformatf("%0d results never arrived", pending_results.size()));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic [95:0] s_tdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  sequence_book               book;
  int unsigned                s_idle_pct;
  int unsigned                m_idle_pct;
  logic [fst_pkg::TIME_W-1:0] now_base;

  // Client pool: entries 0..15 end up in the table, 16..19 are always refused
  logic [fst_pkg::ADDR_W-1:0] pool_addr [POOL_SIZE];
  logic [fst_pkg::PORT_W-1:0] pool_port [POOL_SIZE];
  logic [fst_pkg::SEQ_W-1:0]  pool_seq  [POOL_SIZE];

  flow_sequence_tracker_top #(
    .TABLE_DEPTH (DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .s_tdata     (s_tdata),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .m_tdata     (m_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: check every accepted result, then pick the next ready at random.
  // Sample right after the edge so values are the ones the edge saw.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) book.check_result(m_tdata);
      m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end
  end

  // Offer one request, idling first at random; return once it is accepted.
  // Always called in the step of a rising edge.
  task automatic send_request(input client_req_t r);
    while ($urandom_range(0, 99) < s_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= r;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    book.note_request(r);
  endtask

  task automatic send_client(input int k, input logic [15:0] seq, input logic [31:0] now);
    client_req_t r;
    r.addr = pool_addr[k];
    r.port = pool_port[k];
    r.seq  = seq;
    r.now  = now;
    send_request(r);
  endtask

  // Random request: mostly known clients with plausible sequences and a time
  // that creeps forward on the scale of the timeout, plus refused clients,
  // stray sequences, long jumps and times from anywhere (including the past).
  task automatic send_random(input int unsigned tmo);
    client_req_t r;
    int          k;
    int unsigned pick;
    int unsigned roll;
    pick = $urandom_range(0, 99);
    if (pick < 80)      k = $urandom_range(0, DEPTH - 1);
    else if (pick < 88) k = $urandom_range(DEPTH, POOL_SIZE - 1);
    else                k = -1;
    if (k < 0) begin
      r.addr = $urandom;
      r.port = 16'($urandom);
    end else begin
      r.addr = pool_addr[k];
      r.port = pool_port[k];
    end
    roll = $urandom_range(0, 99);
    if (k >= 0 && roll < 60)      r.seq = pool_seq[k] + 16'($urandom_range(0, 3));
    else if (k >= 0 && roll < 75) r.seq = pool_seq[k] - 16'($urandom_range(1, 50));
    else if (k >= 0 && roll < 85) r.seq = pool_seq[k];
    else                          r.seq = 16'($urandom);
    // advance the client's sequence except on deliberate step-backs
    if (k >= 0 && (roll < 60 || roll >= 85)) pool_seq[k] = r.seq;
    roll = $urandom_range(0, 99);
    if (roll < 80)      now_base += $urandom_range(0, tmo / 8 + 2);
    else if (roll < 90) now_base += $urandom_range(0, tmo * 2 + 4);
    else if (roll < 95) now_base += $urandom_range(0, 32'h0FFF_FFFF);
    if (roll < 95) r.now = now_base;
    else           r.now = $urandom;
    send_request(r);
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (book.pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the timeout register; the block is idle whenever this is called
  task automatic write_timeout(input logic [15:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    book.timeout = value;
  endtask

  initial begin
    logic [fst_pkg::TMO_W-1:0] tmo_plan [NUM_PHASES];
    book = new();

    // Drive every input to a known value and hold reset
    rst         <= 1'b1;
    s_tdata     <= '0;
    s_tvalid    <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= fst_pkg::TIMEOUT_RESET;
    s_idle_pct  = 15;
    m_idle_pct  = 82;
    now_base    = 32'd1000;

    tmo_plan[0] = 16'd0;
    tmo_plan[1] = 16'hFFFF;
    tmo_plan[2] = 16'd1;
    tmo_plan[3] = 16'($urandom_range(2, 65534));
    tmo_plan[4] = fst_pkg::TIMEOUT_RESET;
    tmo_plan[5] = 16'd30;

    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_addr[k] = $urandom;
      pool_port[k] = 16'($urandom);
      pool_seq[k]  = 16'($urandom);
    end
    // Pin the extreme clients and two near misses of client 3
    pool_addr[0]  = 32'h0000_0000;
    pool_port[0]  = 16'h0000;
    pool_addr[1]  = 32'hFFFF_FFFF;
    pool_port[1]  = 16'hFFFF;
    pool_addr[2]  = 32'h8000_0001;
    pool_port[2]  = 16'h8000;
    pool_addr[16] = pool_addr[3];
    pool_port[16] = ~pool_port[3];
    pool_addr[17] = ~pool_addr[3];
    pool_port[17] = pool_port[3];

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset timeout of 120 s
    send_client(0, 16'd0, 32'd0);         // append first client
    send_client(0, 16'd5, 32'd10);        // in-order update
    send_client(0, 16'd5, 32'd20);        // equal sequence updates, no report
    send_client(0, 16'd3, 32'd30);        // step back: out of order, entry kept
    send_client(1, 16'hFFFF, 32'd40);     // all-ones client appended
    send_client(0, 16'd1, 32'd150);       // own entry expired: smaller seq taken
    send_client(1, 16'd0, 32'd161);       // expired just past the timeout
    send_client(0, 16'd2, 32'd100);       // time in the past never expires
    send_client(2, 16'h1234, 32'd400);    // append; both others age to seq 0
    send_client(0, 16'd9, 32'd401);       // stored sequence now reads 0
    for (int k = 3; k < DEPTH; k++)       // fill the table to its last entry
      send_client(k, pool_seq[k], 32'd402 + k);
    send_client(16, 16'd7, 32'd500);      // near miss on a full table: refused
    send_client(1, 16'hFFFF, 32'hFFFF_FFFF); // time at its top, everything ages
    drain_results();

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    // Each phase starts from an idle block with a new timeout.
    for (int p = 0; p < NUM_PHASES; p++) begin
      s_idle_pct = (p < 2) ? 15 : (p < 4) ? 82 : 0;
      m_idle_pct = (p < 2) ? 82 : (p < 4) ? 15 : 0;
      write_timeout(tmo_plan[p]);
      repeat (ITEMS_PER_PHASE) send_random(32'(tmo_plan[p]));
      drain_results();
    end

    // Let a full table walk pass to catch any stray result
    repeat (DEPTH + 8) @(posedge clk);
    book.close_out();

    $display("Ran %0d requests, %0d results: %0d out of order, %0d new, %0d refused",
             book.n_requests, book.n_results, book.n_ooo, book.n_new, book.n_full);
    $display("Timeouts from 0 to 65535 under sender, receiver and no idling; %0d mismatches",
             book.mismatches);
    if (book.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard limit far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Simulation limit reached before the run completed");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
